// ----- sv/lcfo_pkg.sv -----
// shared types, constants and fixed-point scaling constants for the led colour fade overlay
`timescale 1ns / 1ps
package lcfo_pkg;

	// fade frames and derived widths
	localparam int FADE_FRAMES = 16;
	localparam int FR_W        = $clog2(FADE_FRAMES + 1);
	localparam int FADE_DIV    = FADE_FRAMES - 1;
	localparam int OVP_W       = FR_W + 8;
	localparam int OV_SH       = OVP_W + $clog2(FADE_DIV);
	localparam int OV_RCP      = ((2 ** OV_SH) + FADE_DIV - 1) / FADE_DIV;
	localparam int OV_RCP_W    = $clog2(OV_RCP + 1);
	localparam int OV_ML_W     = OVP_W + OV_RCP_W;
	localparam int LV_W        = OV_ML_W - OV_SH;

	// brightness scaling, divide by one hundred through a reciprocal
	localparam int PCT_MAX   = 100;
	localparam int BR_W      = 7;
	localparam int PROD_W    = 8 + BR_W;
	localparam int PCT_SH    = PROD_W + $clog2(PCT_MAX);
	localparam int PCT_RCP   = ((2 ** PCT_SH) + PCT_MAX - 1) / PCT_MAX;
	localparam int PCT_RCP_W = $clog2(PCT_RCP + 1);
	localparam int PCT_ML_W  = PROD_W + PCT_RCP_W;

	// register reset values
	localparam logic [7:0]      FADE_PEAK_RST = 8'd255;
	localparam logic [7:0]      STEP_MS_RST   = 8'd10;
	localparam logic [BR_W-1:0] BRIGHT_RST    = BR_W'(PCT_MAX);
	localparam logic [7:0]      MS_MAX        = 8'd255;

	// configuration register indexes
	localparam logic REG_FADE_PEAK = 1'b0;
	localparam logic REG_STEP_MS   = 1'b1;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_FADE   = 2'd1,
		MODE_COLOR  = 2'd2,
		MODE_BRIGHT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CH_NONE  = 2'd0,
		CH_RED   = 2'd1,
		CH_GREEN = 2'd2,
		CH_BLUE  = 2'd3
	} chan_t;

	// snapshot of one item after the state update
	typedef struct packed {
		logic            accepted;
		logic            emit;
		logic            framed;
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [BR_W-1:0] bright;
		chan_t           ov_ch;
		logic [FR_W-1:0] ov_n;
		logic [7:0]      ov_peak;
	} snap_t;

	// products handed to the final stage
	typedef struct packed {
		logic              accepted;
		logic              emit;
		logic              framed;
		chan_t             ov_ch;
		logic [PROD_W-1:0] prod_r;
		logic [PROD_W-1:0] prod_g;
		logic [PROD_W-1:0] prod_b;
		logic [OVP_W-1:0]  ovp;
	} prod_t;

endpackage

// ----- sv/lcfo_state.sv -----
// configuration registers, plus colour state and fade sequencing updated per accepted beat
`timescale 1ns / 1ps
module lcfo_state
	import lcfo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_mode,
	input  logic [39:0] in_data,
	input  logic        nxt_ready,
	output logic        v_s1,
	output snap_t       snap_s1
);

	logic [7:0]      fade_peak_q;
	logic [7:0]      step_ms_q;
	logic [7:0]      red_q, green_q, blue_q;
	logic [BR_W-1:0] bright_q;
	chan_t           ov_ch_q;
	logic [FR_W-1:0] ov_n_q;
	logic [7:0]      ov_peak_q;
	logic [FR_W-1:0] frames_q;
	chan_t           target_q;
	logic [7:0]      ms_q;
	logic            pending_q;

	logic [7:0]      in_red, in_green, in_blue, in_bright;
	chan_t           in_chan;
	logic [4:0]      in_count;
	logic            fire;
	logic            stage_ready;
	logic [7:0]      ms_inc;
	logic            frame_run;
	logic            last_frame;

	chan_t           ov_ch_d;
	logic [FR_W-1:0] ov_n_d;
	logic [7:0]      ov_peak_d;
	logic [FR_W-1:0] frames_d;
	chan_t           target_d;
	logic [7:0]      ms_d;
	logic            pending_d;
	logic [7:0]      red_d, green_d, blue_d;
	logic [BR_W-1:0] bright_d;
	logic            accepted_d;
	logic            emit_d;

	assign in_red    = in_data[7:0];
	assign in_green  = in_data[15:8];
	assign in_blue   = in_data[23:16];
	assign in_bright = in_data[31:24];
	assign in_chan   = chan_t'(in_data[33:32]);
	assign in_count  = in_data[38:34];

	assign cfg_ready   = 1'b1;
	assign stage_ready = !v_s1 || nxt_ready;
	assign in_ready    = stage_ready;
	assign fire        = in_valid && stage_ready;

	assign ms_inc     = (ms_q == MS_MAX) ? ms_q : ms_q + 8'd1;
	assign frame_run  = (mode_t'(in_mode) == MODE_TICK) && (frames_q != '0) &&
		(ms_inc >= step_ms_q);
	assign last_frame = (frames_q == FR_W'(1));

	always_comb begin
		ov_ch_d    = ov_ch_q;
		ov_n_d     = ov_n_q;
		ov_peak_d  = ov_peak_q;
		frames_d   = frames_q;
		target_d   = target_q;
		ms_d       = ms_q;
		pending_d  = pending_q;
		red_d      = red_q;
		green_d    = green_q;
		blue_d     = blue_q;
		bright_d   = bright_q;
		accepted_d = 1'b1;
		emit_d     = 1'b0;
		case (mode_t'(in_mode))
			MODE_TICK: begin
				ms_d = ms_inc;
				if (frame_run) begin
					ms_d     = 8'd0;
					frames_d = frames_q - FR_W'(1);
					// overlay kept as channel, frame index and peak; level comes later
					if (target_q != CH_NONE) begin
						ov_ch_d   = target_q;
						ov_n_d    = frames_q - FR_W'(1);
						ov_peak_d = fade_peak_q;
					end
					if (last_frame) begin
						ov_ch_d  = CH_NONE;
						target_d = CH_NONE;
					end
				end
				emit_d    = frame_run || pending_q;
				pending_d = 1'b0;
			end
			MODE_FADE: begin
				target_d = in_chan;
				if (32'(in_count) > FADE_FRAMES) begin
					frames_d = FR_W'(FADE_FRAMES);
				end else begin
					frames_d = FR_W'(in_count);
				end
			end
			MODE_COLOR: begin
				red_d     = in_red;
				green_d   = in_green;
				blue_d    = in_blue;
				pending_d = 1'b1;
			end
			MODE_BRIGHT: begin
				if (in_bright > 8'(PCT_MAX)) begin
					accepted_d = 1'b0;
				end else if (in_bright[BR_W-1:0] != bright_q) begin
					bright_d  = in_bright[BR_W-1:0];
					pending_d = 1'b1;
				end
			end
			default: begin
				accepted_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_peak_q <= FADE_PEAK_RST;
			step_ms_q   <= STEP_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_FADE_PEAK) begin
				fade_peak_q <= cfg_data;
			end else if (cfg_index == REG_STEP_MS) begin
				step_ms_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
			bright_q  <= BRIGHT_RST;
			ov_ch_q   <= CH_NONE;
			ov_n_q    <= '0;
			ov_peak_q <= '0;
			frames_q  <= '0;
			target_q  <= CH_NONE;
			ms_q      <= '0;
			pending_q <= 1'b0;
		end else if (fire) begin
			red_q     <= red_d;
			green_q   <= green_d;
			blue_q    <= blue_d;
			bright_q  <= bright_d;
			ov_ch_q   <= ov_ch_d;
			ov_n_q    <= ov_n_d;
			ov_peak_q <= ov_peak_d;
			frames_q  <= frames_d;
			target_q  <= target_d;
			ms_q      <= ms_d;
			pending_q <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stage_ready) begin
			v_s1 <= in_valid;
		end
	end

	// snapshot uses the colour state seen by this beat and the updated overlay
	always_ff @(posedge clk) begin
		if (fire) begin
			snap_s1.accepted <= accepted_d;
			snap_s1.emit     <= emit_d;
			snap_s1.framed   <= frame_run;
			snap_s1.red      <= red_q;
			snap_s1.green    <= green_q;
			snap_s1.blue     <= blue_q;
			snap_s1.bright   <= bright_q;
			snap_s1.ov_ch    <= ov_ch_d;
			snap_s1.ov_n     <= ov_n_d;
			snap_s1.ov_peak  <= ov_peak_d;
		end
	end

endmodule

// ----- sv/lcfo_scale.sv -----
// product stage: colour times brightness and overlay frame times peak
`timescale 1ns / 1ps
module lcfo_scale
	import lcfo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  v_s1,
	input  snap_t snap_s1,
	output logic  ready_s1,
	input  logic  nxt_ready,
	output logic  v_s2,
	output prod_t prod_s2
);

	logic fire;

	assign ready_s1 = !v_s2 || nxt_ready;
	assign fire     = v_s1 && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			prod_s2.accepted <= snap_s1.accepted;
			prod_s2.emit     <= snap_s1.emit;
			prod_s2.framed   <= snap_s1.framed;
			prod_s2.ov_ch    <= snap_s1.ov_ch;
			prod_s2.prod_r   <= PROD_W'(snap_s1.red) * PROD_W'(snap_s1.bright);
			prod_s2.prod_g   <= PROD_W'(snap_s1.green) * PROD_W'(snap_s1.bright);
			prod_s2.prod_b   <= PROD_W'(snap_s1.blue) * PROD_W'(snap_s1.bright);
			prod_s2.ovp      <= OVP_W'(snap_s1.ov_n) * OVP_W'(snap_s1.ov_peak);
		end
	end

endmodule

// ----- sv/lcfo_mix.sv -----
// final stage: reciprocal divides, overlay add with saturation, output register
`timescale 1ns / 1ps
module lcfo_mix
	import lcfo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s2,
	input  prod_t       prod_s2,
	output logic        ready_s2,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_user,
	output logic [23:0] out_data
);

	logic [PCT_ML_W-1:0] ml_r, ml_g, ml_b;
	logic [OV_ML_W-1:0]  ml_ov;
	logic [LV_W-1:0]     lvl;
	logic [7:0]          lvl8;
	logic [7:0]          ov_r, ov_g, ov_b;
	logic [8:0]          sum_r, sum_g, sum_b;
	logic [7:0]          ch_r, ch_g, ch_b;
	logic                fire;

	// exact floor division by multiply and shift
	assign ml_r  = PCT_ML_W'(prod_s2.prod_r) * PCT_ML_W'(PCT_RCP);
	assign ml_g  = PCT_ML_W'(prod_s2.prod_g) * PCT_ML_W'(PCT_RCP);
	assign ml_b  = PCT_ML_W'(prod_s2.prod_b) * PCT_ML_W'(PCT_RCP);
	assign ml_ov = OV_ML_W'(prod_s2.ovp) * OV_ML_W'(OV_RCP);
	assign lvl   = ml_ov[OV_ML_W-1:OV_SH];
	assign lvl8  = (lvl > LV_W'(255)) ? 8'hff : lvl[7:0];

	assign ov_r = (prod_s2.framed && prod_s2.ov_ch == CH_RED)   ? lvl8 : 8'd0;
	assign ov_g = (prod_s2.framed && prod_s2.ov_ch == CH_GREEN) ? lvl8 : 8'd0;
	assign ov_b = (prod_s2.framed && prod_s2.ov_ch == CH_BLUE)  ? lvl8 : 8'd0;

	assign sum_r = {1'b0, ml_r[PCT_SH+7:PCT_SH]} + {1'b0, ov_r};
	assign sum_g = {1'b0, ml_g[PCT_SH+7:PCT_SH]} + {1'b0, ov_g};
	assign sum_b = {1'b0, ml_b[PCT_SH+7:PCT_SH]} + {1'b0, ov_b};

	assign ch_r = sum_r[8] ? 8'hff : sum_r[7:0];
	assign ch_g = sum_g[8] ? 8'hff : sum_g[7:0];
	assign ch_b = sum_b[8] ? 8'hff : sum_b[7:0];

	assign ready_s2 = !out_valid || out_ready;
	assign fire     = v_s2 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_user <= {prod_s2.emit, prod_s2.accepted};
			out_data <= prod_s2.emit ? {ch_g, ch_r, ch_b} : 24'd0;
		end
	end

endmodule

// ----- sv/led_color_fade_overlay.sv -----
// top level of the single led colour engine with fade overlay
// throughput: one beat per cycle; each stage holds while the stage after it is full
// the path is state update, product stage, then divide, overlay add and output register
// reset: brightness 100, colour, overlay, fade and tick counter cleared,
// fade_peak 255, step_ms 10, pipeline emptied
`timescale 1ns / 1ps
module led_color_fade_overlay
	import lcfo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// red, green, blue, brightness, fade_channel, fade_count, zero pad
	input  logic [39:0] s_axis_tdata,
	// mode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// color_word
	output logic [23:0] m_axis_tdata,
	// accepted, frame_valid
	output logic [1:0]  m_axis_tuser
);

	logic  v_s1;
	snap_t snap_s1;
	logic  ready_s1;
	logic  v_s2;
	prod_t prod_s2;
	logic  ready_s2;

	lcfo_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.nxt_ready (ready_s1),
		.v_s1      (v_s1),
		.snap_s1   (snap_s1)
	);

	lcfo_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.snap_s1   (snap_s1),
		.ready_s1  (ready_s1),
		.nxt_ready (ready_s2),
		.v_s2      (v_s2),
		.prod_s2   (prod_s2)
	);

	lcfo_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s2      (v_s2),
		.prod_s2   (prod_s2),
		.ready_s2  (ready_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_user  (m_axis_tuser),
		.out_data  (m_axis_tdata)
	);

endmodule
